// File: sv/gcc_pkg.sv
`default_nettype none

package gcc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VC_W         = 7;
    localparam int ENTRY_W      = 8;

    typedef logic [VIDX_W-1:0]       t_vidx;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [MAX_VERTICES-1:0] t_row;

    // column summary handed from the column tracker to the control
    typedef struct packed {
        logic  done;
        logic  last;
        logic  has_u;
        logic  has_v;
        t_vidx u;
        t_vidx v;
    } t_column;

    function automatic t_count used_count(input logic [VC_W-1:0] vc);
        t_count n;
        if (vc == '0) begin
            n = t_count'(1);
        end else if (int'(vc) > MAX_VERTICES) begin
            n = t_count'(MAX_VERTICES);
        end else begin
            n = t_count'(vc);
        end
        return n;
    endfunction

    function automatic t_row below_mask(input t_count n);
        t_row m;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            m[i] = (t_count'(i) < n);
        end
        return m;
    endfunction

    // lowest set bit
    function automatic t_vidx first_set(input t_row bits);
        t_vidx idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = t_vidx'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: sv/gcc_ram.sv
`default_nettype none

module gcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/gcc_column.sv
`default_nettype none

module gcc_column
    import gcc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic signed [ENTRY_W-1:0] i_entry,
    input  wire logic                      i_last,
    input  wire t_count                    i_count,
    output t_column                        o_column
);

    t_vidx r_row_pos;
    logic  r_first_valid;
    t_vidx r_first;
    logic  r_second_valid;
    t_vidx r_second;

    t_vidx row;
    logic  is_one;
    logic  first_valid;
    t_vidx first;
    logic  second_valid;
    t_vidx second;
    logic  col_end;

    always_comb begin
        row = r_row_pos;
        if (t_count'(r_row_pos) >= t_count'(MAX_VERTICES)) begin
            row = t_vidx'(MAX_VERTICES - 1);
        end
        is_one       = (i_entry == ENTRY_W'(1));
        first_valid  = r_first_valid;
        first        = r_first;
        second_valid = r_second_valid;
        second       = r_second;
        if (is_one) begin
            if (!r_first_valid) begin
                first_valid = 1'b1;
                first       = row;
            end else begin
                second_valid = 1'b1;
                second       = row;
            end
        end
        col_end = i_last || ((t_count'(row) + t_count'(1)) >= i_count);

        o_column.done  = i_accept && col_end;
        o_column.last  = i_last;
        o_column.has_u = first_valid;
        o_column.has_v = second_valid;
        o_column.u     = first;
        o_column.v     = second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos      <= '0;
            r_first_valid  <= 1'b0;
            r_first        <= '0;
            r_second_valid <= 1'b0;
            r_second       <= '0;
        end else if (i_accept) begin
            if (col_end) begin
                r_row_pos      <= '0;
                r_first_valid  <= 1'b0;
                r_first        <= '0;
                r_second_valid <= 1'b0;
                r_second       <= '0;
            end else begin
                r_row_pos      <= row + t_vidx'(1);
                r_first_valid  <= first_valid;
                r_first        <= first;
                r_second_valid <= second_valid;
                r_second       <= second;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/graph_connectivity_check.sv
// Graph connectivity check over a streamed incidence matrix.
// Slave stream: one incidence entry per transaction, column by column,
// vertex_count entries per column; tlast marks the final entry of the
// matrix. Master stream: one result per matrix (connected, reached count).
// The vertex count register resets to 1. The user writes it through i_cfg_wr_en/
// i_cfg_wr_data only while the block is idle; the block does not enforce it.
// Entries inside a column are taken one per cycle. A column that names an
// edge is written into the adjacency memory by read-modify-write: a read,
// then a write of row u and, for two vertices, of row v; tready stays low.
// After the last entry (and the commit, if the final column names a vertex)
// the walk expands each reached vertex once: S_W_POP reads a pending row,
// S_W_EXP merges it; the result is registered when nothing is pending and
// the output register is free. tready stays low for the whole walk.
// The adjacency memory rows carry valid bits, so clearing between
// matrices needs no pass over the memory.
// Reset clears the column tracker, the row valid bits and the output valid.
// A result waiting on a stalled receiver does not block new entries; only
// the next result waits until the output register is free.
`default_nettype none

module graph_connectivity_check
    import gcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [VC_W-1:0]    i_cfg_wr_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // entry[7:0]
    input  wire logic               s_axis_tlast,   // last_of_matrix
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [7:0]         m_axis_tdata    // connected, reached_count[7:1]
);

    typedef enum logic [2:0] {
        S_IN,
        S_CRD_U,
        S_CWR_U,
        S_CWR_V,
        S_W_POP,
        S_W_EXP
    } t_state;

    t_state           r_state, n_state;
    logic [VC_W-1:0]  r_vertex_count;
    t_column          r_col, n_col;
    t_row             r_row_valid, n_row_valid;
    t_row             r_visited, n_visited;
    t_row             r_pending, n_pending;
    t_vidx            r_cur, n_cur;
    t_count           r_reached, n_reached;
    logic             r_out_valid, n_out_valid;
    logic             r_out_conn, n_out_conn;
    logic [VC_W-1:0]  r_out_count, n_out_count;

    t_count  count;
    t_row    mask;
    t_column column;
    logic    in_accept;
    logic    ram_we;
    t_vidx   ram_waddr;
    t_row    ram_wdata;
    t_vidx   ram_raddr;
    t_row    ram_rdata;
    t_vidx   row_addr;
    t_row    row_q;
    t_row    fresh;
    t_vidx   pick;

    assign count     = used_count(r_vertex_count);
    assign mask      = below_mask(count);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IN);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_conn};

    gcc_column u_column (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_entry  (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_count  (count),
        .o_column (column)
    );

    gcc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row_valid = r_row_valid;
        n_visited   = r_visited;
        n_pending   = r_pending;
        n_cur       = r_cur;
        n_reached   = r_reached;
        n_out_valid = r_out_valid;
        n_out_conn  = r_out_conn;
        n_out_count = r_out_count;
        ram_we      = 1'b0;
        ram_waddr   = r_col.u;
        ram_wdata   = '0;
        ram_raddr   = r_col.u;
        pick        = first_set(r_pending);

        // row that was read last cycle; an unwritten row reads as zero
        unique case (r_state)
            S_CWR_U: row_addr = r_col.u;
            S_CWR_V: row_addr = r_col.v;
            default: row_addr = r_cur;
        endcase
        row_q = r_row_valid[row_addr] ? ram_rdata : '0;
        fresh = row_q & mask & ~r_visited;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IN: begin
                if (column.done) begin
                    n_col = column;
                    if (column.has_u) begin
                        n_state = S_CRD_U;
                    end else if (column.last) begin
                        n_visited = t_row'(1);
                        n_pending = t_row'(1);
                        n_reached = '0;
                        n_state   = S_W_POP;
                    end
                end
            end
            S_CRD_U: begin
                ram_raddr = r_col.u;
                n_state   = S_CWR_U;
            end
            S_CWR_U: begin
                ram_we    = 1'b1;
                ram_waddr = r_col.u;
                ram_wdata = row_q;
                ram_wdata[r_col.has_v ? r_col.v : r_col.u] = 1'b1;
                n_row_valid[r_col.u] = 1'b1;
                ram_raddr = r_col.v;
                if (r_col.has_v) begin
                    n_state = S_CWR_V;
                end else if (r_col.last) begin
                    n_visited = t_row'(1);
                    n_pending = t_row'(1);
                    n_reached = '0;
                    n_state   = S_W_POP;
                end else begin
                    n_state = S_IN;
                end
            end
            S_CWR_V: begin
                ram_we    = 1'b1;
                ram_waddr = r_col.v;
                ram_wdata = row_q;
                ram_wdata[r_col.u] = 1'b1;
                n_row_valid[r_col.v] = 1'b1;
                if (r_col.last) begin
                    n_visited = t_row'(1);
                    n_pending = t_row'(1);
                    n_reached = '0;
                    n_state   = S_W_POP;
                end else begin
                    n_state = S_IN;
                end
            end
            S_W_POP: begin
                ram_raddr = pick;
                if (r_pending != '0) begin
                    // every reached vertex is expanded exactly once
                    n_pending[pick] = 1'b0;
                    n_cur     = pick;
                    n_reached = r_reached + t_count'(1);
                    n_state   = S_W_EXP;
                end else if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_conn  = (r_reached == count);
                    n_out_count = VC_W'(r_reached);
                    n_row_valid = '0;
                    n_state     = S_IN;
                end
            end
            S_W_EXP: begin
                n_visited = r_visited | fresh;
                n_pending = r_pending | fresh;
                n_state   = S_W_POP;
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IN;
            r_vertex_count <= VC_W'(1);
            r_row_valid    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
        end
        r_col       <= n_col;
        r_visited   <= n_visited;
        r_pending   <= n_pending;
        r_cur       <= n_cur;
        r_reached   <= n_reached;
        r_out_conn  <= n_out_conn;
        r_out_count <= n_out_count;
    end

    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_W_POP))
        else $error("result appeared outside the walk");

    a_result_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("result reached count is zero");

    a_root_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_POP || r_state == S_W_EXP) |-> r_visited[0])
        else $error("walk running without vertex 0 visited");

    a_pending_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_POP || r_state == S_W_EXP) |-> ((r_pending & ~r_visited) == '0))
        else $error("pending vertex not marked visited");

    a_no_accept_in_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRD_U) |=> (r_state == S_CWR_U))
        else $error("commit read not followed by write");

endmodule

`default_nettype wire

// File: tb/graph_connectivity_check_tb.sv
`timescale 1ns / 1ps

module graph_connectivity_check_tb;
    import gcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 2 * MAX_VERTICES + 32;
    localparam int unsigned RX_HOLD_CYCLES = 400;

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH
    } t_flow_mode;

    typedef enum int {
        COL_LINK,
        COL_SELF_LOOP,
        COL_EMPTY,
        COL_SCATTER
    } t_column_kind;

    typedef struct {
        logic [7:0] value;
        logic       closes;
    } t_incidence_item;

    typedef struct packed {
        logic [6:0] reached;
        logic       connected;
    } t_graph_verdict;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [VC_W-1:0]   i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;     // entry[7:0]
    logic              s_axis_tlast = 1'b0;   // last_of_matrix
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;          // connected, reached_count[7:1]

    graph_connectivity_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_incidence_item entry_queue[$];
    t_graph_verdict  expected_verdicts[$];
    int unsigned     queued_items = 0;
    int unsigned     mismatches = 0;
    int unsigned     cycle_count = 0;
    int unsigned     tx_idle_pct = 0;
    int unsigned     rx_stall_pct = 0;
    logic            rx_hold_flip = 1'b0;
    logic            rx_hold_seen = 1'b0;
    int unsigned     rx_hold_left = 0;

    // local copy of the block state
    logic [VC_W-1:0] vc_model = VC_W'(1);
    t_row            adjacency_model[MAX_VERTICES];
    int unsigned     col_row = 0;
    int unsigned     u_row = 0;
    int unsigned     v_row = 0;
    logic            u_seen = 1'b0;
    logic            v_seen = 1'b0;

    initial begin
        foreach (adjacency_model[i]) adjacency_model[i] = '0;
    end

    function automatic int unsigned vertices_in_use(input logic [VC_W-1:0] count);
        if (count == '0) begin
            return 1;
        end
        return (int'(count) > MAX_VERTICES) ? MAX_VERTICES : int'(count);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    task automatic apply_incidence_entry(input logic [7:0] value, input logic closes);
        int unsigned    n;
        int unsigned    cur;
        int unsigned    reached;
        int unsigned    frontier[$];
        t_row           seen;
        t_graph_verdict verdict;
        n = vertices_in_use(vc_model);
        if (col_row > MAX_VERTICES - 1) begin
            col_row = MAX_VERTICES - 1;
        end
        if (value == 8'd1) begin
            if (!u_seen) begin
                u_row = col_row;
                u_seen = 1'b1;
            end else begin
                v_row = col_row;
                v_seen = 1'b1;
            end
        end
        if (closes || col_row + 1 >= n) begin
            if (u_seen && v_seen) begin
                adjacency_model[u_row][v_row] = 1'b1;
                adjacency_model[v_row][u_row] = 1'b1;
            end else if (u_seen) begin
                adjacency_model[u_row][u_row] = 1'b1;
            end
            col_row = 0;
            u_seen = 1'b0;
            v_seen = 1'b0;
        end else begin
            col_row++;
        end
        if (closes) begin
            // reachability from vertex 0, only vertices below the count
            seen = '0;
            seen[0] = 1'b1;
            reached = 1;
            frontier.push_back(0);
            while (frontier.size() != 0) begin
                cur = frontier.pop_back();
                for (int unsigned i = 0; i < n; i++) begin
                    if (adjacency_model[cur][i] && !seen[i]) begin
                        seen[i] = 1'b1;
                        reached++;
                        frontier.push_back(i);
                    end
                end
            end
            verdict.connected = (reached == n);
            verdict.reached = 7'(reached);
            expected_verdicts.push_back(verdict);
            foreach (adjacency_model[i]) adjacency_model[i] = '0;
        end
    endtask

    // sender
    always @(posedge i_clk) begin : driver
        t_incidence_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_incidence_entry(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (entry_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    item = entry_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= item.value;
                    s_axis_tlast <= item.closes;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold_left <= 0;
            rx_hold_seen <= rx_hold_flip;
        end else if (rx_hold_flip != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_flip;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_graph_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with no matrix pending, tdata", m_axis_tdata, 0);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.connected) begin
                    report_mismatch("connected", m_axis_tdata[0], want.connected);
                end
                if (m_axis_tdata[7:1] !== want.reached) begin
                    report_mismatch("reached_count", m_axis_tdata[7:1], want.reached);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("graph_connectivity_check_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if ($urandom_range(3) == 0) begin
            return 8'd0;
        end
        do begin
            b = 8'($urandom);
        end while (b == 8'd1);
        return b;
    endfunction

    task automatic push_entry(input logic [7:0] value, input logic closes);
        t_incidence_item item;
        item.value = value;
        item.closes = closes;
        entry_queue.push_back(item);
        queued_items++;
    endtask

    function automatic t_row pick_column(input int unsigned n);
        t_row         ones;
        int unsigned  a;
        int unsigned  b;
        int unsigned  roll;
        t_column_kind kind;
        ones = '0;
        roll = $urandom_range(19);
        if (roll < 12) begin
            kind = COL_LINK;
        end else if (roll < 15) begin
            kind = COL_SELF_LOOP;
        end else if (roll < 17) begin
            kind = COL_EMPTY;
        end else begin
            kind = COL_SCATTER;
        end
        if (n < 2 && kind == COL_LINK) begin
            kind = COL_SELF_LOOP;
        end
        case (kind)
            COL_LINK: begin
                a = $urandom_range(n - 1);
                do begin
                    b = $urandom_range(n - 1);
                end while (b == a);
                ones[a] = 1'b1;
                ones[b] = 1'b1;
            end
            COL_SELF_LOOP: begin
                ones[$urandom_range(n - 1)] = 1'b1;
            end
            COL_EMPTY: begin
                ones = '0;
            end
            default: begin
                // random ones; when there are two or more, the last of them names v
                for (int unsigned i = 0; i < n; i++) begin
                    ones[i] = ($urandom_range(n) < 2);
                end
            end
        endcase
        return ones;
    endfunction

    task automatic push_column(input int unsigned n, input t_row ones, input logic closes);
        for (int unsigned r = 0; r < n; r++) begin
            push_entry(ones[r] ? 8'd1 : noise_byte(), closes && (r == n - 1));
        end
    endtask

    // spanning puts a random tree into the first columns; it covers all vertices with at least n-1 columns
    task automatic push_matrix(input int unsigned n, input int unsigned columns,
                               input bit spanning);
        t_row ones;
        for (int unsigned c = 0; c < columns; c++) begin
            if (spanning && c + 1 < n) begin
                ones = '0;
                ones[c + 1] = 1'b1;
                ones[$urandom_range(c)] = 1'b1;
            end else begin
                ones = pick_column(n);
            end
            push_column(n, ones, c == columns - 1);
        end
    endtask

    // matrix cut short: tlast may fall inside a column
    task automatic push_broken(input int unsigned n);
        int unsigned k;
        repeat ($urandom_range(2)) push_column(n, pick_column(n), 1'b0);
        k = $urandom_range(n - 1);
        for (int unsigned r = 0; r <= k; r++) begin
            push_entry(($urandom_range(2) == 0) ? 8'd1 : noise_byte(), r == k);
        end
    endtask

    task automatic fill_random_phase(input int unsigned budget);
        int unsigned n;
        int unsigned start;
        int unsigned k;
        n = vertices_in_use(vc_model);
        start = queued_items;
        while (queued_items - start < budget) begin
            case ($urandom_range(9))
                0: push_broken(n);
                1: repeat ($urandom_range(5, 15)) begin
                    push_entry(8'($urandom), $urandom_range(19) == 0);
                end
                default: begin
                    if (n > 16) begin
                        push_matrix(n, $urandom_range(1, 3), 1'b0);
                    end else begin
                        push_matrix(n, $urandom_range(1, 2 * n), $urandom_range(2) == 0);
                    end
                end
            endcase
        end
        // sometimes leave a column open so the next count change lands mid-column
        if (n > 1 && $urandom_range(2) == 0) begin
            k = $urandom_range(n - 2);
            for (int unsigned r = 0; r <= k; r++) begin
                push_entry(($urandom_range(2) == 0) ? 8'd1 : noise_byte(), 1'b0);
            end
        end
    endtask

    task automatic set_flow(input t_flow_mode mode);
        case (mode)
            FLOW_SENDER_GAPS: begin
                tx_idle_pct = 66;
                rx_stall_pct = 0;
            end
            FLOW_RECEIVER_STALLS: begin
                tx_idle_pct = 0;
                rx_stall_pct = 66;
            end
            FLOW_BOTH: begin
                tx_idle_pct = 8;
                rx_stall_pct = 8;
            end
            default: begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    // all items taken, all results back, then room for a walk in progress
    task automatic wait_graph_quiet();
        @(negedge i_clk);
        while (entry_queue.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [VC_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        vc_model = value;
    endtask

    initial begin : stimulus
        logic [VC_W-1:0] vc;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one vertex at reset count: self-loop, empty column, self-loop closing the matrix, result
        set_flow(FLOW_FREE);
        push_entry(8'd1, 1'b0);
        push_entry(8'h80, 1'b0);
        push_entry(8'd1, 1'b1);
        wait_graph_quiet();
        // zero count behaves as one
        write_vertex_count('0);
        push_entry(8'h7f, 1'b1);
        wait_graph_quiet();
        write_vertex_count(VC_W'(3));
        // repeated ones (last wins), self-loop, empty column, tlast mid-column
        push_entry(8'd1, 1'b0);
        push_entry(8'd1, 1'b0);
        push_entry(8'd1, 1'b0);
        push_entry(8'hff, 1'b0);
        push_entry(8'd1, 1'b0);
        push_entry(8'h00, 1'b0);
        push_entry(8'h80, 1'b0);
        push_entry(8'h7f, 1'b0);
        push_entry(8'h02, 1'b0);
        push_entry(8'd1, 1'b1);
        // self-loop on vertex 1, edge 0-2: vertex 1 not reached, not connected
        push_entry(8'hfe, 1'b0);
        push_entry(8'd1, 1'b0);
        push_entry(8'h81, 1'b0);
        push_entry(8'd1, 1'b0);
        push_entry(8'd1, 1'b0);
        push_entry(8'd1, 1'b1);
        // open column, then shrink the count under it
        push_entry(8'd1, 1'b0);
        push_entry(8'h00, 1'b0);
        wait_graph_quiet();
        write_vertex_count(VC_W'(2));
        push_entry(8'd1, 1'b0);
        push_entry(8'd1, 1'b0);
        push_entry(8'd1, 1'b1);

        // tree over sixteen vertices: every vertex reached
        wait_graph_quiet();
        write_vertex_count(VC_W'(16));
        push_matrix(16, 15, 1'b1);

        // largest register value, clamped count
        wait_graph_quiet();
        set_flow(FLOW_SENDER_GAPS);
        write_vertex_count('1);
        push_matrix(MAX_VERTICES, $urandom_range(1, 3), 1'b0);
        push_broken(MAX_VERTICES);

        // receiver holds off while small matrices keep coming in
        wait_graph_quiet();
        set_flow(FLOW_FREE);
        write_vertex_count(VC_W'(2));
        @(posedge i_clk);
        rx_hold_flip <= ~rx_hold_flip;
        repeat (40) push_matrix(2, 2, 1'b0);

        for (int p = 0; p < 10; p++) begin
            wait_graph_quiet();
            set_flow(t_flow_mode'(p % 4));
            case ($urandom_range(9))
                0: vc = '0;
                1: vc = VC_W'($urandom_range(MAX_VERTICES, 127));
                2: vc = VC_W'(1);
                default: vc = VC_W'($urandom_range(2, 9));
            endcase
            write_vertex_count(vc);
            fill_random_phase(100);
        end

        wait_graph_quiet();
        if (mismatches == 0) begin
            $display("graph_connectivity_check_tb OK");
        end else begin
            $display("graph_connectivity_check_tb NOT OK");
        end
        $finish;
    end

endmodule
